@@ hw/rtl/hpsd_pkg.sv @@
// hpsd_pkg: shared types, character codes and helpers for the hex point string decoder
// used by the channel interfaces and every module of the decoder; no dependencies

package hpsd_pkg;

    localparam int CHAR_W  = 8;
    localparam int COORD_W = 15;
    localparam int SCALE_W = 15;
    localparam int RAW_W   = 8;
    localparam int NIB_W   = 4;
    localparam int PROD_W  = RAW_W + SCALE_W;

    // scale is in 1/256 units, rounding adds one half
    localparam int                 SCALE_SHIFT = 8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
    localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(256 / 2);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;  // 'F'
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;  // 'f'
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;  // ' '
    localparam logic [CHAR_W-1:0] HEX_TEN    = 8'd10;

    // place of the next character inside a four-character group
    typedef enum logic [1:0] {
        POS_X_HI = 2'd0,
        POS_X_LO = 2'd1,
        POS_Y_HI = 2'd2,
        POS_Y_LO = 2'd3
    } t_pos;

    // unscaled point handed from the parser to the scaler
    typedef struct packed {
        logic             valid;
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
        logic             closing;
    } t_point;

    // hex digit value, anything that is not a hex digit counts as zero
    function automatic logic [NIB_W-1:0] hex_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            d = ch - CHAR_ZERO;
        end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
            d = ch - CHAR_UA + HEX_TEN;
        end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
            d = ch - CHAR_LA + HEX_TEN;
        end
        return d[NIB_W-1:0];
    endfunction

endpackage

@@ hw/rtl/hpsd_ifs.sv @@
// hpsd channel interfaces: character input, point output and scale register write
// depends on hpsd_pkg for field widths

interface hpsd_char_if;
    import hpsd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface hpsd_point_if;
    import hpsd_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               is_closing;

    modport source (output valid, output x_coord, output y_coord, output is_closing,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input is_closing,
                    output ready);
endinterface

interface hpsd_cfg_if;
    import hpsd_pkg::*;
    logic               valid;
    logic               ready;
    logic [SCALE_W-1:0] scale_factor;

    modport source (output valid, output scale_factor, input ready);
    modport sink   (input valid, input scale_factor, output ready);
endinterface

@@ hw/rtl/hpsd_parse.sv @@
// hpsd_parse: group parser, subpath start memory and point selection
// depends on hpsd_pkg (t_pos, t_point, hex_value, character codes)

module hpsd_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [hpsd_pkg::CHAR_W-1:0] i_char,
    input  logic                      i_eos,
    output hpsd_pkg::t_point          o_point
);
    import hpsd_pkg::*;

    t_pos              r_pos, n_pos;
    logic [RAW_W-1:0]  r_part_x, n_part_x;
    logic [NIB_W-1:0]  r_part_y, n_part_y;
    logic              r_after_sep, n_after_sep;
    logic              r_have_start, n_have_start;
    logic [RAW_W-1:0]  r_start_x, n_start_x;
    logic [RAW_W-1:0]  r_start_y, n_start_y;

    logic [NIB_W-1:0]  w_digit;
    logic [RAW_W-1:0]  w_y_full;

    assign w_digit  = hex_value(i_char);
    assign w_y_full = {r_part_y, w_digit};

    // parser state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_X_HI;
            r_part_x     <= '0;
            r_part_y     <= '0;
            r_after_sep  <= 1'b0;
            r_have_start <= 1'b0;
            r_start_x    <= '0;
            r_start_y    <= '0;
        end else if (i_go) begin
            r_pos        <= n_pos;
            r_part_x     <= n_part_x;
            r_part_y     <= n_part_y;
            r_after_sep  <= n_after_sep;
            r_have_start <= n_have_start;
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
        end
    end

    // next state and emitted point for one character
    always_comb begin
        n_pos        = r_pos;
        n_part_x     = r_part_x;
        n_part_y     = r_part_y;
        n_after_sep  = r_after_sep;
        n_have_start = r_have_start;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        o_point.valid   = 1'b0;
        o_point.x       = r_start_x;
        o_point.y       = r_start_y;
        o_point.closing = 1'b1;

        if (i_eos) begin
            // close the open subpath and start afresh
            o_point.valid = i_go && r_have_start;
            n_pos        = POS_X_HI;
            n_part_x     = '0;
            n_part_y     = '0;
            n_after_sep  = 1'b0;
            n_have_start = 1'b0;
            n_start_x    = '0;
            n_start_y    = '0;
        end else begin
            case (r_pos)
                POS_X_HI: begin
                    if (i_char == CHAR_DOT) begin
                        n_after_sep   = 1'b1;
                        o_point.valid = i_go && r_have_start;
                    end else if (i_char != CHAR_SPACE) begin
                        n_part_x = {w_digit, {NIB_W{1'b0}}};
                        n_pos    = POS_X_LO;
                    end
                end
                POS_X_LO: begin
                    n_part_x = r_part_x | {{NIB_W{1'b0}}, w_digit};
                    n_pos    = POS_Y_HI;
                end
                POS_Y_HI: begin
                    n_part_y = w_digit;
                    n_pos    = POS_Y_LO;
                end
                POS_Y_LO: begin
                    o_point.valid   = i_go;
                    o_point.x       = r_part_x;
                    o_point.y       = w_y_full;
                    o_point.closing = 1'b0;
                    // first point after a separator becomes the subpath start
                    if (r_after_sep) begin
                        n_start_x    = r_part_x;
                        n_start_y    = w_y_full;
                        n_have_start = 1'b1;
                        n_after_sep  = 1'b0;
                    end
                    n_pos    = POS_X_HI;
                    n_part_x = '0;
                    n_part_y = '0;
                end
                default: begin
                    n_pos = POS_X_HI;
                end
            endcase
        end
    end

    // end of string leaves a clean parser
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_eos |=> r_pos == POS_X_HI && !r_have_start && !r_after_sep)
        else $error("parser not cleared after end of string");

    // a closing point needs a remembered start
    a_close_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_point.valid && o_point.closing |-> r_have_start)
        else $error("closing point without subpath start");

    // the fourth character of a group always emits and restarts the group
    a_group_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && !i_eos && r_pos == POS_Y_LO |-> o_point.valid ##1 r_pos == POS_X_HI)
        else $error("completed group did not emit a point");

endmodule

@@ hw/rtl/hpsd_scale.sv @@
// hpsd_scale: coordinate scaling and the output result register
// depends on hpsd_pkg (t_point, widths, rounding constants) and hpsd_point_if

module hpsd_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hpsd_pkg::t_point             i_point,
    input  logic [hpsd_pkg::SCALE_W-1:0] i_scale,
    output logic                         o_free,
    hpsd_point_if.source                 o_out
);
    import hpsd_pkg::*;

    logic               r_valid;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_closing;

    logic [PROD_W-1:0]  w_prod_x;
    logic [PROD_W-1:0]  w_prod_y;
    logic [PROD_W-1:0]  w_round_x;
    logic [PROD_W-1:0]  w_round_y;

    // (v * scale + 128) / 256, the sum stays inside the product width
    assign w_prod_x  = PROD_W'(i_point.x) * PROD_W'(i_scale);
    assign w_prod_y  = PROD_W'(i_point.y) * PROD_W'(i_scale);
    assign w_round_x = w_prod_x + ROUND_HALF;
    assign w_round_y = w_prod_y + ROUND_HALF;

    // output register takes a new point once the old one is gone
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_point.valid) begin
            r_x       <= w_round_x[SCALE_SHIFT +: COORD_W];
            r_y       <= w_round_y[SCALE_SHIFT +: COORD_W];
            r_closing <= i_point.closing;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.x_coord    = r_x;
    assign o_out.y_coord    = r_y;
    assign o_out.is_closing = r_closing;

endmodule

@@ hw/rtl/hex_point_string_decoder_top.sv @@
// hex_point_string_decoder_top: character input register, scale register, parser and scaler
// depends on hpsd_pkg, hpsd_ifs (channel interfaces), hpsd_parse and hpsd_scale
//
// usage
//   i_char  : one character request per cycle (char_code, end_of_string);
//             every four hex characters make a point, '.' closes a subpath,
//             end_of_string closes the open subpath and clears the parser
//   o_point : scaled point requests (x_coord, y_coord, is_closing)
//   i_cfg   : scale_factor write, always ready; write only while idle
// latency: a character taken at edge n gives its point at the output after
//   edge n+1 (two cycles request to request); characters with no point just
//   update the parser
// throughput: one character per cycle, set by the single parser stage and
//   the output register; the input register lets a character be taken while
//   a point waits at the output
// reset: scale_factor returns to 256, parser and subpath start are cleared,
//   both registers are empty; no clearing pass
// stall: when o_point is held, the output register keeps its point, the
//   input register fills once and i_char.ready drops until the point leaves

module hex_point_string_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hpsd_char_if.sink    i_char,
    hpsd_cfg_if.sink     i_cfg,
    hpsd_point_if.source o_point
);
    import hpsd_pkg::*;

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_eos;
    logic [SCALE_W-1:0] r_scale;

    logic   w_free;
    logic   w_go;
    t_point w_point;

    // character moves into the parser once the output side can take its point
    assign w_go         = r_in_valid && w_free;
    assign i_char.ready = !r_in_valid || w_go;
    assign i_cfg.ready  = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_code;
            r_in_eos  <= i_char.end_of_string;
        end
    end

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg.valid) begin
            r_scale <= i_cfg.scale_factor;
        end
    end

    hpsd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_char  (r_in_char),
        .i_eos   (r_in_eos),
        .o_point (w_point)
    );

    hpsd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_point (w_point),
        .i_scale (r_scale),
        .o_free  (w_free),
        .o_out   (o_point)
    );

endmodule
